### hw/rtl/ldr_pkg.sv
// ----------------------------------------------------------------------------
// Lens distortion remap package
// Shared types and constants for the lens distortion remap pipeline.
// ----------------------------------------------------------------------------
package ldr_pkg;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_K1     = 3'd0,
		REG_K2     = 3'd1,
		REG_K3     = 3'd2,
		REG_P1     = 3'd3,
		REG_P2     = 3'd4,
		REG_FX     = 3'd5,
		REG_FY     = 3'd6,
		REG_CENTER = 3'd7
	} reg_idx_t;

	// Live configuration as seen by the datapath.
	typedef struct packed {
		logic signed [23:0] k1;
		logic signed [23:0] k2;
		logic signed [23:0] k3;
		logic signed [23:0] p1;
		logic signed [23:0] p2;
		logic [19:0]        fx;
		logic [19:0]        fy;
		logic [15:0]        cx;
		logic [15:0]        cy;
	} cfg_t;

	// Reset values of the configuration registers.
	localparam logic [23:0] K1_RST     = 24'hFEE62A;
	localparam logic [23:0] K2_RST     = 24'd106564;
	localparam logic [23:0] K3_RST     = 24'hFF610E;
	localparam logic [23:0] P1_RST     = 24'hFFFE00;
	localparam logic [23:0] P2_RST     = 24'hFFF8ED;
	localparam logic [19:0] FX_RST     = 20'd228617;
	localparam logic [19:0] FY_RST     = 20'd229311;
	localparam logic [31:0] CENTER_RST = 32'd552216315;

	// Normalizer: quotient bits and total latency (setup, steps, clamp).
	localparam int QBITS   = 23;
	localparam int DIV_LAT = QBITS + 2;

	// Normalized coordinate width (signed Q2.20).
	localparam int NW = 23;

endpackage

### hw/rtl/ldr_norm.sv
// ----------------------------------------------------------------------------
// Coordinate normalizer
// Computes (pos*16 - center) * 2^24 / focal, truncated toward zero and
// clamped to signed Q2.20, with a restoring divider of one bit per stage.
// ----------------------------------------------------------------------------
module ldr_norm import ldr_pkg::*; #(
	parameter int POS_W = 11
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic [POS_W-1:0]     pos,
	input  logic [15:0]          center,
	input  logic [19:0]          focal,
	output logic signed [NW-1:0] norm
);

	localparam int UW    = ((POS_W + 4) > 16 ? (POS_W + 4) : 16) + 1;
	localparam int REM_W = (UW > 21) ? UW : 21;

	logic [UW-1:0]    diff;
	logic [UW-2:0]    mag;
	logic [REM_W-1:0] rem0;
	logic             ovf0;

	logic [REM_W-1:0] rem_q [0:QBITS];
	logic [QBITS-1:0] quo_q [0:QBITS];
	logic             neg_q [0:QBITS];
	logic             ovf_q [0:QBITS];

	logic [REM_W:0]   dbl   [0:QBITS-1];
	logic             ge    [0:QBITS-1];
	logic [REM_W-1:0] nrem  [0:QBITS-1];

	logic [QBITS-1:0] qfin;

	// Offset from the center and its magnitude; the quotient overflows 23 bits
	// as soon as twice the magnitude reaches the focal length.
	always_comb begin
		diff = UW'({pos, 4'b0000}) - UW'(center);
		mag  = diff[UW-1] ? (UW-1)'(-diff) : diff[UW-2:0];
		rem0 = REM_W'({mag, 1'b0});
		ovf0 = rem0 >= REM_W'(focal);
	end

	// One restoring step per stage.
	always_comb begin
		for (int i = 0; i < QBITS; i++) begin
			dbl[i]  = {rem_q[i], 1'b0};
			ge[i]   = dbl[i] >= (REM_W+1)'(focal);
			nrem[i] = ge[i] ? REM_W'(dbl[i] - (REM_W+1)'(focal)) : dbl[i][REM_W-1:0];
		end
	end

	// Divider stage registers.
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0] <= rem0;
			quo_q[0] <= '0;
			neg_q[0] <= diff[UW-1];
			ovf_q[0] <= ovf0;
			for (int i = 0; i < QBITS; i++) begin
				rem_q[i+1] <= nrem[i];
				quo_q[i+1] <= {quo_q[i][QBITS-2:0], ge[i]};
				neg_q[i+1] <= neg_q[i];
				ovf_q[i+1] <= ovf_q[i];
			end
		end
	end

	// Signed clamp to [-4, 4).
	assign qfin = quo_q[QBITS];

	always_ff @(posedge clk) begin
		if (en) begin
			if (neg_q[QBITS]) begin
				if (ovf_q[QBITS] || qfin[QBITS-1])
					norm <= {1'b1, {(NW-1){1'b0}}};
				else
					norm <= NW'(-qfin);
			end else begin
				if (ovf_q[QBITS] || qfin[QBITS-1])
					norm <= {1'b0, {(NW-1){1'b1}}};
				else
					norm <= NW'(qfin);
			end
		end
	end

endmodule

### hw/rtl/ldr_poly.sv
// ----------------------------------------------------------------------------
// Distortion polynomial
// Applies the radial and tangential terms to a normalized coordinate pair,
// maps it back to pixel space and checks it against the frame.
// ----------------------------------------------------------------------------
module ldr_poly import ldr_pkg::*; #(
	parameter int FRAME_WIDTH  = 1280,
	parameter int FRAME_HEIGHT = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  cfg_t                 cfg,
	input  logic                 in_vld,
	input  logic [7:0]           in_val,
	input  logic signed [NW-1:0] x,
	input  logic signed [NW-1:0] y,
	output logic                 out_vld,
	output logic [10:0]          out_col,
	output logic [9:0]           out_row,
	output logic [7:0]           out_val
);

	// Stage 1: squares and cross product.
	logic signed [45:0] xx_p, yy_p, xy_p;
	logic signed [25:0] xx_s1, yy_s1, xy_s1;
	logic signed [NW-1:0] x_s1, y_s1;
	logic vld_s1;
	logic [7:0] val_s1;

	assign xx_p = x * x;
	assign yy_p = y * y;
	assign xy_p = x * y;

	always_ff @(posedge clk) begin
		if (en) begin
			xx_s1  <= xx_p[45:20];
			yy_s1  <= yy_p[45:20];
			xy_s1  <= xy_p[45:20];
			x_s1   <= x;
			y_s1   <= y;
			val_s1 <= in_val;
		end
	end

	// Stage 2: radius squared and tangential sums.
	logic signed [26:0] r2_s2;
	logic signed [27:0] ax_s2, ay_s2;
	logic signed [25:0] xy_s2;
	logic signed [NW-1:0] x_s2, y_s2;
	logic vld_s2;
	logic [7:0] val_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			r2_s2  <= 27'(xx_s1) + 27'(yy_s1);
			ax_s2  <= 28'(xx_s1) + 28'(yy_s1) + (28'(xx_s1) <<< 1);
			ay_s2  <= 28'(xx_s1) + 28'(yy_s1) + (28'(yy_s1) <<< 1);
			xy_s2  <= xy_s1;
			x_s2   <= x_s1;
			y_s2   <= y_s1;
			val_s2 <= val_s1;
		end
	end

	// Stage 3: r^4, first radial term and tangential offsets.
	logic signed [53:0] r4_p;
	logic signed [50:0] kr2_p;
	logic signed [49:0] p1xy_p, p2xy_p;
	logic signed [51:0] p2ax_p, p1ay_p;
	logic signed [31:0] dx_c, dy_c;
	logic signed [31:0] r4_s3, dx_s3, dy_s3;
	logic signed [30:0] kr2_s3;
	logic signed [26:0] r2_s3;
	logic signed [NW-1:0] x_s3, y_s3;
	logic vld_s3;
	logic [7:0] val_s3;

	assign r4_p   = r2_s2 * r2_s2;
	assign kr2_p  = cfg.k1 * r2_s2;
	assign p1xy_p = cfg.p1 * xy_s2;
	assign p2xy_p = cfg.p2 * xy_s2;
	assign p2ax_p = cfg.p2 * ax_s2;
	assign p1ay_p = cfg.p1 * ay_s2;
	assign dx_c   = 32'($signed(p1xy_p[49:19])) + 32'(p2ax_p[51:20]);
	assign dy_c   = 32'(p1ay_p[51:20]) + 32'($signed(p2xy_p[49:19]));

	always_ff @(posedge clk) begin
		if (en) begin
			r4_s3  <= r4_p[51:20];
			kr2_s3 <= kr2_p[50:20];
			dx_s3  <= dx_c;
			dy_s3  <= dy_c;
			r2_s3  <= r2_s2;
			x_s3   <= x_s2;
			y_s3   <= y_s2;
			val_s3 <= val_s2;
		end
	end

	// Stage 4: r^6 and second radial term.
	logic signed [58:0] r6_p;
	logic signed [55:0] kr4_p;
	logic signed [36:0] r6_s4;
	logic signed [35:0] kr4_s4;
	logic signed [30:0] kr2_s4;
	logic signed [31:0] dx_s4, dy_s4;
	logic signed [NW-1:0] x_s4, y_s4;
	logic vld_s4;
	logic [7:0] val_s4;

	assign r6_p  = r4_s3 * r2_s3;
	assign kr4_p = cfg.k2 * r4_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			r6_s4  <= r6_p[56:20];
			kr4_s4 <= kr4_p[55:20];
			kr2_s4 <= kr2_s3;
			dx_s4  <= dx_s3;
			dy_s4  <= dy_s3;
			x_s4   <= x_s3;
			y_s4   <= y_s3;
			val_s4 <= val_s3;
		end
	end

	// Stage 5: third radial term and radial scale.
	logic signed [60:0] kr6_p;
	logic signed [41:0] scale_s5;
	logic signed [31:0] dx_s5, dy_s5;
	logic signed [NW-1:0] x_s5, y_s5;
	logic vld_s5;
	logic [7:0] val_s5;

	assign kr6_p = cfg.k3 * r6_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			scale_s5 <= 42'sd1048576 + 42'(kr2_s4) + 42'(kr4_s4)
				+ 42'($signed(kr6_p[60:20]));
			dx_s5    <= dx_s4;
			dy_s5    <= dy_s4;
			x_s5     <= x_s4;
			y_s5     <= y_s4;
			val_s5   <= val_s4;
		end
	end

	// Stage 6: distorted coordinates, saturated to 2^15 focal units.
	localparam logic signed [45:0] LIM_HI = 46'sd34359738367;
	localparam logic signed [45:0] LIM_LO = -46'sd34359738368;

	logic signed [64:0] xs_p, ys_p;
	logic signed [45:0] xs_c, ys_c;
	logic signed [35:0] xb_s6, yb_s6;
	logic vld_s6;
	logic [7:0] val_s6;

	assign xs_p = x_s5 * scale_s5;
	assign ys_p = y_s5 * scale_s5;
	assign xs_c = 46'($signed(xs_p[64:20])) + 46'(dx_s5);
	assign ys_c = 46'($signed(ys_p[64:20])) + 46'(dy_s5);

	always_ff @(posedge clk) begin
		if (en) begin
			xb_s6  <= (xs_c > LIM_HI) ? 36'(LIM_HI) : ((xs_c < LIM_LO) ? 36'(LIM_LO) : 36'(xs_c));
			yb_s6  <= (ys_c > LIM_HI) ? 36'(LIM_HI) : ((ys_c < LIM_LO) ? 36'(LIM_LO) : 36'(ys_c));
			val_s6 <= val_s5;
		end
	end

	// Stage 7: back to pixel space and frame check.
	logic signed [56:0] xf_p, yf_p;
	logic signed [57:0] xc, yc;
	logic in_frame;

	assign xf_p = xb_s6 * $signed({1'b0, cfg.fx});
	assign yf_p = yb_s6 * $signed({1'b0, cfg.fy});
	assign xc   = 58'(xf_p) + $signed({18'b0, cfg.cx, 24'b0});
	assign yc   = 58'(yf_p) + $signed({18'b0, cfg.cy, 24'b0});

	always_comb begin
		in_frame = !xc[57] && !yc[57]
			&& (xc[57:28] < 30'(FRAME_WIDTH)) && (yc[57:28] < 30'(FRAME_HEIGHT))
			&& (cfg.fx != '0) && (cfg.fy != '0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_col <= xc[38:28];
			out_row <= yc[37:28];
			out_val <= val_s6;
		end
	end

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			out_vld <= 1'b0;
		end else if (en) begin
			vld_s1  <= in_vld;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			out_vld <= vld_s6 && in_frame;
		end
	end

endmodule

### hw/rtl/lens_distortion_pixel_remap_core.sv
// ----------------------------------------------------------------------------
// Lens distortion pixel remap core
// Brown-Conrady scatter-write address generator for a preloaded frame store.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_stall) carries one grey pixel with its
// column and row per transaction. The output channel (out_valid, out_stall)
// carries the pixel with its corrected address. A pixel whose corrected
// address falls outside the frame, or any pixel while a focal length is
// zero, yields no output transaction.
// Throughput is one pixel per clock unless the receiver stalls. Pixels pass
// through the coordinate normalizers, which are restoring dividers producing
// one quotient bit per stage, then through the distortion polynomial pipeline.
// The configuration port writes one register per cycle with cfg_we; write
// it only while the pipeline is empty.
// Reset clears all valid bits and loads the default lens calibration.
// While the receiver stalls a pending output, the whole pipeline holds and
// in_stall is raised; no transaction is lost or repeated.
// ----------------------------------------------------------------------------
module lens_distortion_pixel_remap_core import ldr_pkg::*; #(
	parameter int FRAME_WIDTH  = 1280,
	parameter int FRAME_HEIGHT = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [10:0] src_col,
	input  logic [9:0]  src_row,
	input  logic [7:0]  src_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [10:0] dst_col,
	output logic [9:0]  dst_row,
	output logic [7:0]  dst_value
);

	cfg_t cfg_q;
	logic pipe_en;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.k1 <= K1_RST;
			cfg_q.k2 <= K2_RST;
			cfg_q.k3 <= K3_RST;
			cfg_q.p1 <= P1_RST;
			cfg_q.p2 <= P2_RST;
			cfg_q.fx <= FX_RST;
			cfg_q.fy <= FY_RST;
			cfg_q.cx <= CENTER_RST[15:0];
			cfg_q.cy <= CENTER_RST[31:16];
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_K1:     cfg_q.k1 <= cfg_data[23:0];
				REG_K2:     cfg_q.k2 <= cfg_data[23:0];
				REG_K3:     cfg_q.k3 <= cfg_data[23:0];
				REG_P1:     cfg_q.p1 <= cfg_data[23:0];
				REG_P2:     cfg_q.p2 <= cfg_data[23:0];
				REG_FX:     cfg_q.fx <= cfg_data[19:0];
				REG_FY:     cfg_q.fy <= cfg_data[19:0];
				REG_CENTER: begin
					cfg_q.cx <= cfg_data[15:0];
					cfg_q.cy <= cfg_data[31:16];
				end
				default:    ;
			endcase
		end
	end

	// The pipeline advances unless a finished result is held by the receiver.
	assign pipe_en  = !(out_valid && out_stall);
	assign in_stall = !pipe_en;

	// Normalized coordinates.
	logic signed [NW-1:0] norm_x, norm_y;

	ldr_norm #(.POS_W(11)) u_norm_x (
		.clk    (clk),
		.en     (pipe_en),
		.pos    (src_col),
		.center (cfg_q.cx),
		.focal  (cfg_q.fx),
		.norm   (norm_x)
	);

	ldr_norm #(.POS_W(10)) u_norm_y (
		.clk    (clk),
		.en     (pipe_en),
		.pos    (src_row),
		.center (cfg_q.cy),
		.focal  (cfg_q.fy),
		.norm   (norm_y)
	);

	// Valid bits and grey levels alongside the normalizers.
	logic       vld_q [0:DIV_LAT-1];
	logic [7:0] val_q [0:DIV_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIV_LAT; i++)
				vld_q[i] <= 1'b0;
		end else if (pipe_en) begin
			vld_q[0] <= in_valid;
			for (int i = 1; i < DIV_LAT; i++)
				vld_q[i] <= vld_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			val_q[0] <= src_value;
			for (int i = 1; i < DIV_LAT; i++)
				val_q[i] <= val_q[i-1];
		end
	end

	// Distortion, back-projection and frame check.
	ldr_poly #(
		.FRAME_WIDTH  (FRAME_WIDTH),
		.FRAME_HEIGHT (FRAME_HEIGHT)
	) u_poly (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (pipe_en),
		.cfg     (cfg_q),
		.in_vld  (vld_q[DIV_LAT-1]),
		.in_val  (val_q[DIV_LAT-1]),
		.x       (norm_x),
		.y       (norm_y),
		.out_vld (out_valid),
		.out_col (dst_col),
		.out_row (dst_row),
		.out_val (dst_value)
	);

	// A held pipeline keeps its valid bits.
	assert property (@(posedge clk) disable iff (!arst_n)
		!pipe_en |=> $stable(vld_q[DIV_LAT-1]) && $stable(vld_q[0]))
		else $error("valid bits moved while the pipeline was held");

	// A new output transaction appears only after the pipeline advanced.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(pipe_en))
		else $error("output appeared while the pipeline was held");

	// An emitted row always lies inside the frame.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (32'(dst_row) < 32'(FRAME_HEIGHT)))
		else $error("emitted row lies outside the frame");

endmodule

### tb/tb_lens_distortion_pixel_remap_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Lens distortion remap core testbench
// Drives pixels through the remap core under several lens calibrations,
// predicts each corrected address in fixed point and checks every output
// transaction in order, with random idling and stalls on both channels.
// ----------------------------------------------------------------------------
import ldr_pkg::*;

typedef struct {
	logic [10:0] col;
	logic [9:0]  row;
	logic [7:0]  value;
} remap_pixel_t;

// Scoreboard: holds the live calibration and the queue of expected pixels.
class remap_scoreboard;
	longint k1, k2, k3, p1, p2, fx, fy, cx, cy;
	remap_pixel_t expected_q[$];
	int errors;

	function void set_reg(reg_idx_t idx, logic [31:0] data);
		case (idx)
			REG_K1: k1 = longint'($signed(data[23:0]));
			REG_K2: k2 = longint'($signed(data[23:0]));
			REG_K3: k3 = longint'($signed(data[23:0]));
			REG_P1: p1 = longint'($signed(data[23:0]));
			REG_P2: p2 = longint'($signed(data[23:0]));
			REG_FX: fx = longint'(data[19:0]);
			REG_FY: fy = longint'(data[19:0]);
			REG_CENTER: begin
				cx = longint'(data[15:0]);
				cy = longint'(data[31:16]);
			end
		endcase
	endfunction

	function longint clamp(longint v, longint lo, longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// Floor of v / 2^20.
	function longint q20(longint v);
		return v >>> 20;
	endfunction

	// Position to signed Q2.20 normalized coordinate.
	function longint norm_coord(longint pos, longint center, longint focal);
		longint u;
		u = pos * 16 - center;
		return clamp((u * 64'sd16777216) / focal, -64'sd4194304, 64'sd4194303);
	endfunction

	// Works out the corrected address of one accepted pixel.
	function void note_input(logic [10:0] col, logic [9:0] row, logic [7:0] value);
		longint x, y, xx, yy, xy, r2, r4, r6, scale, dx, dy, xb, yb, xc, yc;
		longint lim;
		remap_pixel_t px;
		lim = 64'sd1 << 35;
		if (fx == 0 || fy == 0)
			return;
		x = norm_coord(longint'(col), cx, fx);
		y = norm_coord(longint'(row), cy, fy);
		xx = q20(x * x);
		yy = q20(y * y);
		xy = q20(x * y);
		r2 = xx + yy;
		r4 = q20(r2 * r2);
		r6 = q20(r4 * r2);
		scale = 64'sd1048576 + q20(k1 * r2) + q20(k2 * r4) + q20(k3 * r6);
		dx = q20(2 * p1 * xy) + q20(p2 * (r2 + 2 * xx));
		dy = q20(p1 * (r2 + 2 * yy)) + q20(2 * p2 * xy);
		xb = clamp(q20(x * scale) + dx, -lim, lim - 1);
		yb = clamp(q20(y * scale) + dy, -lim, lim - 1);
		xc = xb * fx + cx * 64'sd16777216;
		yc = yb * fy + cy * 64'sd16777216;
		if (xc < 0 || yc < 0)
			return;
		if ((xc >>> 28) >= 1280 || (yc >>> 28) >= 1024)
			return;
		px.col = 11'(xc >>> 28);
		px.row = 10'(yc >>> 28);
		px.value = value;
		expected_q.push_back(px);
	endfunction

	// Compares one output transaction with the oldest expected pixel.
	function void check_result(logic [10:0] col, logic [9:0] row, logic [7:0] value);
		remap_pixel_t px;
		if (expected_q.size() == 0) begin
			$display("%0t: unexpected output col=%0d row=%0d value=%0d",
				$time, col, row, value);
			errors++;
			return;
		end
		px = expected_q.pop_front();
		if (col !== px.col) begin
			$display("%0t: dst_col expected %0d actual %0d", $time, px.col, col);
			errors++;
		end
		if (row !== px.row) begin
			$display("%0t: dst_row expected %0d actual %0d", $time, px.row, row);
			errors++;
		end
		if (value !== px.value) begin
			$display("%0t: dst_value expected %0d actual %0d", $time, px.value, value);
			errors++;
		end
	endfunction
endclass

module tb_lens_distortion_pixel_remap_core;
	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	reg_idx_t    cfg_index;
	logic [31:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [10:0] src_col;
	logic [9:0]  src_row;
	logic [7:0]  src_value;
	logic        out_valid;
	logic        out_stall;
	logic [10:0] dst_col;
	logic [9:0]  dst_row;
	logic [7:0]  dst_value;

	remap_scoreboard sb;
	bit idle_enable;
	bit hold_request;

	lens_distortion_pixel_remap_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.src_col   (src_col),
		.src_row   (src_row),
		.src_value (src_value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.dst_col   (dst_col),
		.dst_row   (dst_row),
		.dst_value (dst_value)
	);

	always #5 clk = ~clk;

	// Random gap length: mostly none or short, a few long.
	function automatic int gap_length();
		int r;
		r = $urandom_range(0, 99);
		if (!idle_enable || r < 65)
			return 0;
		if (r < 94)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Receiver stall pattern, with one long hold-off on request.
	initial begin
		int n;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				out_stall <= 1'b1;
				repeat (300) @(posedge clk);
				out_stall <= 1'b0;
			end else begin
				n = gap_length();
				if (n > 0) begin
					out_stall <= 1'b1;
					repeat (n) @(posedge clk);
					out_stall <= 1'b0;
				end
			end
		end
	end

	// Input and output transaction monitors.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.note_input(src_col, src_row, src_value);
		if (arst_n && out_valid && !out_stall)
			sb.check_result(dst_col, dst_row, dst_value);
	end

	// Each task starts and ends at a rising edge.
	task automatic write_reg(reg_idx_t idx, logic [31:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		sb.set_reg(idx, data);
		@(posedge clk);
	endtask

	task automatic write_lens(int a, int b, int c, int d, int e,
			logic [19:0] fxv, logic [19:0] fyv, logic [31:0] ctr);
		write_reg(REG_K1, 32'(a));
		write_reg(REG_K2, 32'(b));
		write_reg(REG_K3, 32'(c));
		write_reg(REG_P1, 32'(d));
		write_reg(REG_P2, 32'(e));
		write_reg(REG_FX, 32'(fxv));
		write_reg(REG_FY, 32'(fyv));
		write_reg(REG_CENTER, ctr);
		cfg_we <= 1'b0;
	endtask

	task automatic send_pixel(logic [10:0] col, logic [9:0] row, logic [7:0] value);
		int n;
		in_valid <= 1'b1;
		src_col <= col;
		src_row <= row;
		src_value <= value;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		n = gap_length();
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Stop sending and wait until the pipeline has drained.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic random_pixels(int count);
		logic [10:0] col;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < 85)
				col = 11'($urandom_range(0, 1279));
			else
				col = 11'($urandom_range(0, 2047));
			send_pixel(col, 10'($urandom_range(0, 1023)), 8'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		sb = new();
		sb.set_reg(REG_K1, 32'(K1_RST));
		sb.set_reg(REG_K2, 32'(K2_RST));
		sb.set_reg(REG_K3, 32'(K3_RST));
		sb.set_reg(REG_P1, 32'(P1_RST));
		sb.set_reg(REG_P2, 32'(P2_RST));
		sb.set_reg(REG_FX, 32'(FX_RST));
		sb.set_reg(REG_FY, 32'(FY_RST));
		sb.set_reg(REG_CENTER, CENTER_RST);
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_K1;
		cfg_data = '0;
		in_valid = 1'b0;
		src_col = '0;
		src_row = '0;
		src_value = '0;
		idle_enable = 1'b1;
		hold_request = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed corners under the reset calibration.
		send_pixel(11'd0, 10'd0, 8'd0);
		send_pixel(11'd1279, 10'd1023, 8'd255);
		send_pixel(11'd1279, 10'd0, 8'hAA);
		send_pixel(11'd0, 10'd1023, 8'h55);
		send_pixel(11'd640, 10'd512, 8'd1);
		send_pixel(11'd2047, 10'd1023, 8'd128);
		send_pixel(11'd1280, 10'd500, 8'd77);
		random_pixels(140);
		drain();

		// No distortion: every in-frame pixel maps near itself.
		write_lens(0, 0, 0, 0, 0, 20'd256000, 20'd256000, {16'd8192, 16'd10240});
		idle_enable = 1'b0;
		random_pixels(40);
		idle_enable = 1'b1;
		random_pixels(60);
		drain();

		// Coefficient extremes, far-from-center saturation.
		write_lens(8388607, -8388608, 8388607, -8388608, 8388607,
			20'd1048575, 20'd1048575, {16'd8192, 16'd10240});
		send_pixel(11'd640, 10'd512, 8'd9);
		random_pixels(30);
		drain();
		write_lens(-8388608, 8388607, -8388608, 8388607, -8388608,
			20'd1048575, 20'd256, 32'h0000_0000);
		send_pixel(11'd0, 10'd0, 8'd3);
		random_pixels(30);
		drain();
		write_lens(-1000, 500, -100, 50, -50, 20'd256, 20'd1048575, 32'hFFFF_FFFF);
		send_pixel(11'd2047, 10'd1023, 8'd4);
		random_pixels(30);
		drain();

		// Zero focal length: nothing comes out.
		write_lens(0, 0, 0, 0, 0, 20'd0, 20'd256000, {16'd8192, 16'd10240});
		random_pixels(10);
		drain();
		write_lens(0, 0, 0, 0, 0, 20'd256000, 20'd0, {16'd8192, 16'd10240});
		random_pixels(10);
		drain();

		// Back to the default lens with a long receiver hold-off.
		write_lens(-72150, 106564, -40690, -512, -1811,
			FX_RST, FY_RST, CENTER_RST);
		hold_request = 1'b1;
		idle_enable = 1'b0;
		random_pixels(60);
		idle_enable = 1'b1;
		random_pixels(60);
		drain();

		if (sb.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Timeout.
	initial begin
		#5ms;
		$display("*** FAILED ***");
		$finish;
	end
endmodule
